[hw/rtl/pses_pkg.sv]
// ----------------------------------------------------------------------------
// pses_pkg
// Shared codes and types of the periodic SPI exchange sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pses_pkg;

   // request opcodes
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_RX_DONE  = 3'd1;
   localparam logic [2:0] OP_RX_ERROR = 3'd2;
   localparam logic [2:0] OP_TX_ERROR = 3'd3;
   localparam logic [2:0] OP_START    = 3'd4;
   localparam logic [2:0] OP_STOP     = 3'd5;
   localparam logic [2:0] OP_CONSUMED = 3'd6;

   // sequencer phases
   localparam logic [2:0] PH_STOPPED = 3'd0;
   localparam logic [2:0] PH_IDLE    = 3'd1;
   localparam logic [2:0] PH_SETUP   = 3'd2;
   localparam logic [2:0] PH_XFER    = 3'd3;
   localparam logic [2:0] PH_HOLD    = 3'd4;

   // published status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_INITIAL_DELAY = 2'd0;
   localparam logic [1:0] CSR_PERIOD        = 2'd1;
   localparam logic [1:0] CSR_GUARD         = 2'd2;

   // reset values of the csr registers
   localparam logic [15:0] INITIAL_DELAY_RESET = 16'd1000;
   localparam logic [15:0] PERIOD_RESET        = 16'd1000;
   localparam logic [7:0]  GUARD_RESET         = 8'd2;

   // request payload, lowest bit first: spi_error, spi_busy, rx_path_clear, now_us
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] now_us;
      logic        rx_path_clear;
      logic        spi_busy;
      logic        spi_error;
   } req_data_type;

   // response payload, lowest bit first
   typedef struct packed {
      logic [6:0]  pad;
      logic [2:0]  phase;
      logic        result_pending;
      logic [31:0] result_time_us;
      logic [1:0]  result_status;
      logic        publish;
      logic        dma_enabled;
      logic        chip_select_low;
   } rsp_data_type;

endpackage

`default_nettype wire

[hw/rtl/periodic_spi_exchange_sequencer.sv]
// ----------------------------------------------------------------------------
// periodic_spi_exchange_sequencer
// Paces a periodic chip-select / DMA exchange on a 1 us tick and publishes
// a timestamped status for each completed or failed exchange but the first after a start.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_tvalid/tready   | tuser opcode, tdata sensor flags + now_us
//  rsp_     | out       | rsp_tvalid/tready   | tdata outputs and status
//  csr_     | in        | csr_valid/ready     | csr_index, csr_data
//
//  each transaction passes through the request register, then the state
//  update into the response register. one request is accepted every cycle
//  unless a stalled response holds a full request register; the state updates in that
//  same cycle the request moves into the response register.
//  a stalled response holds the request register; csr writes are always taken.
//  reset is synchronous; it stops the sequencer and loads the csr defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_spi_exchange_sequencer
   import pses_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // spi_error, spi_busy, rx_path_clear, now_us[31:0], 0
   input  wire logic [2:0]  req_tuser,  // opcode
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // chip_select_low, dma_enabled, publish,
                                        // result_status[1:0], result_time_us[31:0],
                                        // result_pending, phase[2:0], 0
   // csr write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // csr registers
   logic [15:0] init_delay_ff;
   logic [15:0] period_ff;
   logic [7:0]  guard_ff;

   // pipeline registers
   logic         req_valid_ff;
   logic [2:0]   req_op_ff;
   req_data_type req_data_ff;
   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;
   logic         advance;

   // sequencer state
   logic [2:0]  phase_ff,         phase_in;
   logic [15:0] period_count_ff,  period_count_in;
   logic [7:0]  guard_count_ff,   guard_count_in;
   logic        first_release_ff, first_release_in;
   logic        prime_pending_ff, prime_pending_in;
   logic        pending_ff,       pending_in;
   logic [31:0] acq_time_ff,      acq_time_in;
   logic        acq_valid_ff,     acq_valid_in;
   logic [1:0]  held_status_ff,   held_status_in;
   logic [31:0] held_time_ff,     held_time_in;
   logic        publish_in;
   rsp_data_type rsp_data_in;

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_delay_ff <= INITIAL_DELAY_RESET;
         period_ff     <= PERIOD_RESET;
         guard_ff      <= GUARD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INITIAL_DELAY: init_delay_ff <= csr_data;
            CSR_PERIOD:        period_ff     <= csr_data;
            CSR_GUARD:         guard_ff      <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // handshake control
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_op_ff   <= req_tuser;
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // next-state logic for one transaction
   always_comb begin
      logic [15:0] reload;
      logic        pub_req;
      logic [1:0]  pub_status;
      logic [31:0] pub_stamp;
      logic [31:0] stamp;
      logic [31:0] now;

      now              = req_data_ff.now_us;
      stamp            = acq_valid_ff ? acq_time_ff : now;
      reload           = first_release_ff ? init_delay_ff : period_ff;
      pub_req          = 1'b0;
      pub_status       = ST_OK;
      pub_stamp        = now;
      phase_in         = phase_ff;
      period_count_in  = period_count_ff;
      guard_count_in   = guard_count_ff;
      first_release_in = first_release_ff;
      prime_pending_in = prime_pending_ff;
      pending_in       = pending_ff;
      acq_time_in      = acq_time_ff;
      acq_valid_in     = acq_valid_ff;
      held_status_in   = held_status_ff;
      held_time_in     = held_time_ff;
      publish_in       = 1'b0;

      case (req_op_ff)
         OP_TICK: begin
            if (phase_ff != PH_STOPPED) begin
               if (period_count_ff == reload - 16'd1) begin
                  // period fire
                  period_count_in  = '0;
                  first_release_in = 1'b0;
                  if (phase_ff != PH_IDLE) begin
                     phase_in       = PH_IDLE;
                     guard_count_in = '0;
                     pub_req        = 1'b1;
                     pub_status     = ST_BUSY;
                  end else if (!req_data_ff.rx_path_clear) begin
                     phase_in       = PH_IDLE;
                     guard_count_in = '0;
                     pub_req        = 1'b1;
                     pub_status     = ST_ERR;
                  end else begin
                     acq_time_in    = now;
                     acq_valid_in   = 1'b1;
                     phase_in       = PH_SETUP;
                     guard_count_in = '0;
                  end
               end else begin
                  period_count_in = period_count_ff + 16'd1;
                  // guard timer runs in setup and hold
                  if (phase_ff == PH_SETUP || phase_ff == PH_HOLD) begin
                     if (guard_count_ff == guard_ff - 8'd1) begin
                        guard_count_in = '0;
                        if (phase_ff == PH_SETUP) begin
                           if (req_data_ff.spi_error) begin
                              phase_in   = PH_IDLE;
                              pub_req    = 1'b1;
                              pub_status = ST_ERR;
                              pub_stamp  = stamp;
                           end else begin
                              phase_in = PH_XFER;
                           end
                        end else begin
                           phase_in   = PH_IDLE;
                           pub_req    = 1'b1;
                           pub_status = (req_data_ff.spi_error || req_data_ff.spi_busy)
                                        ? ST_ERR : ST_OK;
                           pub_stamp  = stamp;
                        end
                     end else begin
                        guard_count_in = guard_count_ff + 8'd1;
                     end
                  end
               end
            end
         end
         OP_RX_DONE: begin
            if (phase_ff == PH_XFER) begin
               phase_in       = PH_HOLD;
               guard_count_in = '0;
            end
         end
         OP_RX_ERROR, OP_TX_ERROR: begin
            if (phase_ff == PH_XFER) begin
               phase_in       = PH_IDLE;
               guard_count_in = '0;
               pub_req        = 1'b1;
               pub_status     = ST_ERR;
               pub_stamp      = stamp;
            end
         end
         OP_START: begin
            if (phase_ff == PH_STOPPED) begin
               pending_in       = 1'b0;
               acq_time_in      = '0;
               acq_valid_in     = 1'b0;
               first_release_in = 1'b1;
               prime_pending_in = 1'b1;
               period_count_in  = '0;
               guard_count_in   = '0;
               phase_in         = PH_IDLE;
            end
         end
         OP_STOP: begin
            phase_in         = PH_STOPPED;
            pending_in       = 1'b0;
            acq_time_in      = '0;
            acq_valid_in     = 1'b0;
            prime_pending_in = 1'b0;
            period_count_in  = '0;
            guard_count_in   = '0;
         end
         OP_CONSUMED: begin
            pending_in = 1'b0;
         end
         default: ;
      endcase

      // publication: first result after start is dropped, unconsumed turns busy
      if (pub_req) begin
         acq_time_in  = '0;
         acq_valid_in = 1'b0;
         if (prime_pending_ff) begin
            prime_pending_in = 1'b0;
         end else begin
            held_status_in = pending_ff ? ST_BUSY : pub_status;
            held_time_in   = pub_stamp;
            pending_in     = 1'b1;
            publish_in     = 1'b1;
         end
      end

      // response fields
      rsp_data_in                 = '0;
      rsp_data_in.chip_select_low = (phase_in == PH_SETUP) || (phase_in == PH_XFER) ||
                                    (phase_in == PH_HOLD);
      rsp_data_in.dma_enabled     = (phase_in == PH_XFER);
      rsp_data_in.publish         = publish_in;
      rsp_data_in.result_status   = held_status_in;
      rsp_data_in.result_time_us  = held_time_in;
      rsp_data_in.result_pending  = pending_in;
      rsp_data_in.phase           = phase_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_STOPPED;
         period_count_ff  <= '0;
         guard_count_ff   <= '0;
         first_release_ff <= 1'b0;
         prime_pending_ff <= 1'b0;
         pending_ff       <= 1'b0;
         acq_time_ff      <= '0;
         acq_valid_ff     <= 1'b0;
         held_status_ff   <= ST_OK;
         held_time_ff     <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         period_count_ff  <= period_count_in;
         guard_count_ff   <= guard_count_in;
         first_release_ff <= first_release_in;
         prime_pending_ff <= prime_pending_in;
         pending_ff       <= pending_in;
         acq_time_ff      <= acq_time_in;
         acq_valid_ff     <= acq_valid_in;
         held_status_ff   <= held_status_in;
         held_time_ff     <= held_time_in;
      end
   end

endmodule

`default_nettype wire

[verif/tb_periodic_spi_exchange_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_periodic_spi_exchange_sequencer
// Self-checking bench for the periodic SPI exchange sequencer. A clocked
// driver feeds request transactions from a backlog and a clocked monitor
// predicts each response from its own copy of the sequencer state, then
// checks every response field against the oldest prediction. Several timer
// settings are loaded through the csr channel between runs. These include
// firing on every tick and short initial delays, so that exchanges start,
// complete and fail within each run. Both stream sides idle at random, and
// the receiver holds off once for a long stretch so that the request side
// backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_periodic_spi_exchange_sequencer;
   import pses_pkg::*;

   // opcode with no meaning, the block must ignore it
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLDOFF_START = 150;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int BURST_FIRST = 300;
   localparam int BURST_LAST = 400;

   typedef struct {
      logic [2:0]   op;
      req_data_type data;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // spi_error, spi_busy, rx_path_clear, now_us[31:0], 0
   logic [2:0]  req_tuser = '0;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;       // chip_select_low, dma_enabled, publish,
                                 // result_status[1:0], result_time_us[31:0],
                                 // result_pending, phase[2:0], 0
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   req_item_type req_backlog[$];
   req_item_type drive_item;
   rsp_data_type expected_rsp[$];
   rsp_data_type got_rsp;
   rsp_data_type want_rsp;

   int cycle_count = 0;
   int stall_cycles = 0;
   int holdoff_left = 0;
   int failures = 0;

   // sequencer model: timer settings and state
   logic [15:0] cfg_initial_delay;
   logic [15:0] cfg_period;
   logic [7:0]  cfg_guard;
   logic [2:0]  seq_phase;
   logic [15:0] period_cnt;
   logic [7:0]  guard_cnt;
   logic        first_fire;
   logic        discard_next;
   logic        result_waiting;
   logic [31:0] acq_time;
   logic        acq_valid;
   logic [1:0]  held_status;
   logic [31:0] held_time;
   logic        published;

   wire burst_window = (cycle_count >= BURST_FIRST) && (cycle_count < BURST_LAST);

   periodic_spi_exchange_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock and the single reset pulse
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // hand a result over, unless it is the discarded first exchange
   function automatic void post_result(input logic [1:0] status, input logic [31:0] stamp);
      acq_time = '0;
      acq_valid = 1'b0;
      if (discard_next) begin
         discard_next = 1'b0;
      end else begin
         held_status = result_waiting ? ST_BUSY : status;
         held_time = stamp;
         result_waiting = 1'b1;
         published = 1'b1;
      end
   endfunction

   function automatic void abort_exchange(input logic [1:0] status, input logic [31:0] stamp);
      seq_phase = PH_IDLE;
      guard_cnt = '0;
      post_result(status, stamp);
   endfunction

   // advance the model by one request and return the response it implies
   function automatic rsp_data_type sequencer_response(input logic [2:0] op,
                                                       input req_data_type d);
      logic [15:0]  reload;
      logic [31:0]  stamp;
      rsp_data_type r;
      published = 1'b0;
      stamp = acq_valid ? acq_time : d.now_us;
      case (op)
         OP_TICK: begin
            if (seq_phase != PH_STOPPED) begin
               reload = first_fire ? cfg_initial_delay : cfg_period;
               if (period_cnt == reload - 16'd1) begin
                  // period firing, the guard timer restarts from zero on this tick
                  period_cnt = '0;
                  first_fire = 1'b0;
                  if (seq_phase != PH_IDLE) begin
                     abort_exchange(ST_BUSY, d.now_us);
                  end else if (!d.rx_path_clear) begin
                     abort_exchange(ST_ERR, d.now_us);
                  end else begin
                     acq_time = d.now_us;
                     acq_valid = 1'b1;
                     seq_phase = PH_SETUP;
                     guard_cnt = '0;
                  end
               end else begin
                  period_cnt = period_cnt + 16'd1;
                  if (seq_phase == PH_SETUP || seq_phase == PH_HOLD) begin
                     if (guard_cnt == cfg_guard - 8'd1) begin
                        guard_cnt = '0;
                        if (seq_phase == PH_SETUP) begin
                           if (d.spi_error) abort_exchange(ST_ERR, stamp);
                           else seq_phase = PH_XFER;
                        end else begin
                           seq_phase = PH_IDLE;
                           post_result((d.spi_error || d.spi_busy) ? ST_ERR : ST_OK, stamp);
                        end
                     end else begin
                        guard_cnt = guard_cnt + 8'd1;
                     end
                  end
               end
            end
         end
         OP_RX_DONE: begin
            if (seq_phase == PH_XFER) begin
               seq_phase = PH_HOLD;
               guard_cnt = '0;
            end
         end
         OP_RX_ERROR, OP_TX_ERROR: begin
            if (seq_phase == PH_XFER) abort_exchange(ST_ERR, stamp);
         end
         OP_START: begin
            if (seq_phase == PH_STOPPED) begin
               result_waiting = 1'b0;
               acq_time = '0;
               acq_valid = 1'b0;
               first_fire = 1'b1;
               discard_next = 1'b1;
               period_cnt = '0;
               guard_cnt = '0;
               seq_phase = PH_IDLE;
            end
         end
         OP_STOP: begin
            seq_phase = PH_STOPPED;
            result_waiting = 1'b0;
            acq_time = '0;
            acq_valid = 1'b0;
            discard_next = 1'b0;
            period_cnt = '0;
            guard_cnt = '0;
         end
         OP_CONSUMED: begin
            result_waiting = 1'b0;
         end
         default: begin
         end
      endcase
      r = '0;
      r.chip_select_low = (seq_phase == PH_SETUP) || (seq_phase == PH_XFER) ||
                          (seq_phase == PH_HOLD);
      r.dma_enabled = (seq_phase == PH_XFER);
      r.publish = published;
      r.result_status = held_status;
      r.result_time_us = held_time;
      r.result_pending = result_waiting;
      r.phase = seq_phase;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      failures++;
      if (failures <= 10) $display("mismatch %s: expected %0h, actual %0h", what, want, got);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_backlog.size() != 0 && (burst_window || $urandom_range(99, 0) >= 12)) begin
            drive_item = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= drive_item.data;
            req_tuser <= drive_item.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response receiver with one long hold-off
   always @(posedge clock) begin
      if (cycle_count == HOLDOFF_START) begin
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= burst_window || ($urandom_range(99, 0) >= 12);
      end
   end

   // monitor: check responses, track csr writes, predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         cfg_initial_delay = INITIAL_DELAY_RESET;
         cfg_period = PERIOD_RESET;
         cfg_guard = GUARD_RESET;
         seq_phase = PH_STOPPED;
         period_cnt = '0;
         guard_cnt = '0;
         first_fire = 1'b0;
         discard_next = 1'b0;
         result_waiting = 1'b0;
         acq_time = '0;
         acq_valid = 1'b0;
         held_status = ST_OK;
         held_time = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata;
            if (expected_rsp.size() == 0) begin
               flag_mismatch("response without request", 32'd0, 32'd1);
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (got_rsp.chip_select_low !== want_rsp.chip_select_low)
                  flag_mismatch("chip_select_low", 32'(want_rsp.chip_select_low),
                                32'(got_rsp.chip_select_low));
               if (got_rsp.dma_enabled !== want_rsp.dma_enabled)
                  flag_mismatch("dma_enabled", 32'(want_rsp.dma_enabled),
                                32'(got_rsp.dma_enabled));
               if (got_rsp.publish !== want_rsp.publish)
                  flag_mismatch("publish", 32'(want_rsp.publish), 32'(got_rsp.publish));
               if (got_rsp.result_status !== want_rsp.result_status)
                  flag_mismatch("result_status", 32'(want_rsp.result_status),
                                32'(got_rsp.result_status));
               if (got_rsp.result_time_us !== want_rsp.result_time_us)
                  flag_mismatch("result_time_us", want_rsp.result_time_us,
                                got_rsp.result_time_us);
               if (got_rsp.result_pending !== want_rsp.result_pending)
                  flag_mismatch("result_pending", 32'(want_rsp.result_pending),
                                32'(got_rsp.result_pending));
               if (got_rsp.phase !== want_rsp.phase)
                  flag_mismatch("phase", 32'(want_rsp.phase), 32'(got_rsp.phase));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INITIAL_DELAY: cfg_initial_delay = csr_data;
               CSR_PERIOD:        cfg_period = csr_data;
               CSR_GUARD:         cfg_guard = csr_data[7:0];
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(sequencer_response(req_tuser, req_tdata));
         end
      end
   end

   // cycle count and stall tracking for the watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   function automatic void push_req(input logic [2:0] op, input logic err, input logic bsy,
                                    input logic clr, input logic [31:0] now);
      req_item_type it;
      it.op = op;
      it.data = '0;
      it.data.spi_error = err;
      it.data.spi_busy = bsy;
      it.data.rx_path_clear = clr;
      it.data.now_us = now;
      req_backlog.push_back(it);
   endfunction

   // flags mostly in their healthy state, timestamp fully random
   function automatic void push_random(input logic [2:0] op);
      push_req(op, $urandom_range(9, 0) == 0, $urandom_range(9, 0) == 0,
               $urandom_range(9, 0) != 0, $urandom());
   endfunction

   // one run: restart the sequencer, then mostly ticks with dma and host events
   task automatic queue_activity(input int count, input int tick_pct, input int stop_permille);
      int pick;
      push_random(OP_STOP);
      push_random(OP_START);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99, 0);
         if ($urandom_range(99, 0) < tick_pct) begin
            push_random(OP_TICK);
         end else if ($urandom_range(999, 0) < stop_permille) begin
            push_random(OP_STOP);
            if ($urandom_range(3, 0) != 0) push_random(OP_START);
         end else if (pick < 45) begin
            push_random(OP_RX_DONE);
         end else if (pick < 50) begin
            push_random(OP_RX_ERROR);
         end else if (pick < 55) begin
            push_random(OP_TX_ERROR);
         end else if (pick < 85) begin
            push_random(OP_CONSUMED);
         end else if (pick < 93) begin
            push_random(OP_START);
         end else begin
            push_random(OP_UNUSED);
         end
      end
   endtask

   // returns at a rising edge once all requests have been answered
   task automatic wait_drained();
      @(posedge clock);
      wait (req_backlog.size() == 0 && !req_tvalid && expected_rsp.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // write all three timer registers back to back, valid held high throughout
   task automatic load_config(input logic [15:0] delay, input logic [15:0] period,
                              input logic [7:0] guard);
      logic [1:0]  regs [3];
      logic [15:0] vals [3];
      regs = '{CSR_INITIAL_DELAY, CSR_PERIOD, CSR_GUARD};
      vals = '{delay, period, {8'h00, guard}};
      csr_valid <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         csr_index <= regs[k];
         csr_data <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // stimulus sequence
   initial begin
      wait (!reset);
      @(posedge clock);

      // directed: events while stopped, double start, flag and timestamp extremes
      push_req(OP_TICK, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
      push_req(OP_RX_DONE, 1'b0, 1'b0, 1'b1, 32'h0000_0001);
      push_req(OP_RX_ERROR, 1'b1, 1'b0, 1'b0, 32'h8000_0000);
      push_req(OP_TX_ERROR, 1'b0, 1'b1, 1'b0, 32'h7FFF_FFFF);
      push_req(OP_CONSUMED, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
      push_req(OP_UNUSED, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      push_req(OP_STOP, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
      push_req(OP_START, 1'b0, 1'b0, 1'b1, 32'h1234_5678);
      push_req(OP_START, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
      push_req(OP_TICK, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
      push_req(OP_TICK, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
      push_req(OP_RX_DONE, 1'b0, 1'b0, 1'b1, 32'hA5A5_A5A5);
      push_req(OP_RX_ERROR, 1'b0, 1'b0, 1'b1, 32'h5A5A_5A5A);
      push_req(OP_TX_ERROR, 1'b1, 1'b0, 1'b1, 32'hFFFF_0000);
      push_req(OP_CONSUMED, 1'b0, 1'b1, 1'b1, 32'h0000_FFFF);
      push_req(OP_UNUSED, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
      push_req(OP_STOP, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      push_req(OP_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      push_req(OP_START, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
      push_req(OP_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      push_req(OP_STOP, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
      wait_drained();

      // firing on every tick: exchanges only ever end as busy
      load_config(16'd3, 16'd1, 8'd1);
      queue_activity(60, 80, 5);
      wait_drained();

      load_config(16'd2, 16'd6, 8'd1);
      queue_activity(70, 80, 5);
      wait_drained();

      load_config(16'd5, 16'd12, 8'd3);
      queue_activity(70, 80, 5);
      wait_drained();

      for (int p = 0; p < 3; p++) begin
         load_config(16'($urandom_range(8, 1)), 16'($urandom_range(20, 4)),
                     8'($urandom_range(4, 1)));
         queue_activity(70, 80, 5);
         wait_drained();
      end

      load_config(16'd1, 16'd20, 8'd2);
      queue_activity(60, 80, 5);
      wait_drained();

      repeat (10) @(posedge clock);
      if (expected_rsp.size() != 0)
         flag_mismatch("responses outstanding", 32'd0, 32'(expected_rsp.size()));
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
